// File: rtl/crcfs_pkg.sv
// -----------------------------------------------------------------------------
// crcfs_pkg
// Shared widths, codes, types and the CRC byte update for the frame hunter.
// -----------------------------------------------------------------------------
package crcfs_pkg;

	// Field widths of the item and result channels.
	localparam int FUNC_W  = 3;
	localparam int DATA_W  = 8;
	localparam int POS_W   = 7;
	localparam int EVENT_W = 2;
	localparam int FILL_W  = 7;
	localparam int CRC_W   = 16;

	// Default frame length in bytes.
	localparam int FRAME_BYTES_DEF = 73;

	// Reflected CCITT polynomial.
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

	// Function codes of an input item.
	localparam logic [FUNC_W-1:0] FUNC_RX     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TX     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESYNC = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_IDLE   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

	// Event codes of a result item.
	localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EV_CAPT = 2'd1;
	localparam logic [EVENT_W-1:0] EV_ECHO = 2'd2;

	// Control of the shared CRC and compare unit.
	typedef struct packed {
		logic clear;
		logic step;
	} crc_ctl_t;

	// One byte through the reflected CRC, least significant bit first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [DATA_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
		for (int b = 0; b < DATA_W; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/crcfs_if.sv
// -----------------------------------------------------------------------------
// crcfs_if
// Valid/ready channels for input items and result items.
// -----------------------------------------------------------------------------
interface crcfs_in_if;
	logic                          valid;
	logic                          ready;
	logic [crcfs_pkg::FUNC_W-1:0]  func;
	logic [crcfs_pkg::DATA_W-1:0]  data_byte;
	logic [crcfs_pkg::POS_W-1:0]   position;

	modport source (output valid, func, data_byte, position, input ready);
	modport sink (input valid, func, data_byte, position, output ready);
endinterface

interface crcfs_out_if;
	logic                          valid;
	logic                          ready;
	logic [crcfs_pkg::EVENT_W-1:0] event_res;
	logic [crcfs_pkg::DATA_W-1:0]  read_data;
	logic [crcfs_pkg::FILL_W-1:0]  fill_level;

	modport source (output valid, event_res, read_data, fill_level, input ready);
	modport sink (input valid, event_res, read_data, fill_level, output ready);
endinterface

// File: rtl/crcfs_crc_unit.sv
// -----------------------------------------------------------------------------
// crcfs_crc_unit
// Shared byte-wide CRC accumulator with a running byte compare.
// -----------------------------------------------------------------------------
module crcfs_crc_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crcfs_pkg::crc_ctl_t           ctl,
	input  logic [crcfs_pkg::DATA_W-1:0]  win_byte,
	input  logic [crcfs_pkg::DATA_W-1:0]  sent_byte,
	output logic [crcfs_pkg::CRC_W-1:0]   crc,
	output logic                          mismatch
);
	import crcfs_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic             mismatch_q;

	// One window byte per step: fold it into the CRC and compare it to the sent byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			mismatch_q <= 1'b0;
		end else if (ctl.clear) begin
			crc_q      <= '0;
			mismatch_q <= 1'b0;
		end else if (ctl.step) begin
			crc_q      <= crc_byte(crc_q, win_byte);
			mismatch_q <= mismatch_q | (win_byte != sent_byte);
		end
	end

	assign crc      = crc_q;
	assign mismatch = mismatch_q;

endmodule

// File: rtl/crc_frame_sync_echo_filter.sv
// -----------------------------------------------------------------------------
// crc_frame_sync_echo_filter
// Sliding-window frame hunter with CRC check, echo drop and capture store.
// -----------------------------------------------------------------------------
// Each accepted item reaches the output register through S_EMIT; a capture
// read first passes S_RDCAP, an RX item that fills the window runs the CRC
// pass (S_SCAN, S_SCAN_END, S_CHECK), and a found frame is then copied to the
// capture store (S_COPY, S_COPY_END). Throughput: one item at a time; the scan
// and copy each walk the window one byte per cycle, the scan through the CRC unit.
// Reset clears the window fill, the echo mark and all control state; the three
// byte stores hold no defined value until written.
module crc_frame_sync_echo_filter #(
	parameter int FRAME_BYTES = crcfs_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	crcfs_in_if.sink    item,
	crcfs_out_if.source result
);
	import crcfs_pkg::*;

	localparam int IW = $clog2(FRAME_BYTES);
	localparam int FW = $clog2(FRAME_BYTES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);
	localparam logic [FW-1:0] FULL     = FW'(FRAME_BYTES);

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_RDCAP    = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_SCAN_END = 3'd3;
	localparam logic [2:0] S_CHECK    = 3'd4;
	localparam logic [2:0] S_COPY     = 3'd5;
	localparam logic [2:0] S_COPY_END = 3'd6;
	localparam logic [2:0] S_EMIT     = 3'd7;

	logic [2:0]         state_q;
	logic [FW-1:0]      fill_q;
	logic [IW-1:0]      wp_q;
	logic [IW-1:0]      wp_nxt;
	logic [IW-1:0]      ridx_q;
	logic [IW-1:0]      ridx_nxt;
	logic [IW-1:0]      k_q;
	logic [IW-1:0]      k_s1;
	logic               rv_s1;
	logic               echo_q;
	logic [EVENT_W-1:0] ev_q;
	logic [DATA_W-1:0]  rd_q;
	logic               acc;
	logic               pos_ok;
	logic [IW-1:0]      pos_idx;
	logic               out_valid_q;
	logic [EVENT_W-1:0] out_ev_q;
	logic [DATA_W-1:0]  out_rd_q;
	logic [FILL_W-1:0]  out_fill_q;
	logic               out_load;
	logic               cap_we;

	logic [DATA_W-1:0]  win_mem [FRAME_BYTES];
	logic [DATA_W-1:0]  sent_mem [FRAME_BYTES];
	logic [DATA_W-1:0]  cap_mem [FRAME_BYTES];
	logic [DATA_W-1:0]  win_rdata_s1;
	logic [DATA_W-1:0]  sent_rdata_s1;
	logic [DATA_W-1:0]  cap_rdata_q;

	crc_ctl_t           crc_ctl;
	logic [CRC_W-1:0]   crc_val;
	logic               crc_mismatch;

	// Handshake and decode of the accepted transaction.
	assign item.ready = (state_q == S_IDLE);
	assign acc        = item.valid && item.ready;
	assign pos_ok     = (32'(item.position) < FRAME_BYTES);
	assign pos_idx    = IW'(item.position);

	// Circular index increments.
	assign wp_nxt   = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign ridx_nxt = (ridx_q == LAST_IDX) ? '0 : ridx_q + 1'b1;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			wp_q    <= '0;
			ridx_q  <= '0;
			k_q     <= '0;
			rv_s1   <= 1'b0;
			echo_q  <= 1'b0;
			ev_q    <= EV_NONE;
		end else begin
			rv_s1 <= (state_q == S_SCAN) || (state_q == S_COPY);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						ev_q <= EV_NONE;
						unique case (item.func)
							FUNC_RX: begin
								wp_q <= wp_nxt;
								if (fill_q != FULL) begin
									fill_q <= fill_q + 1'b1;
								end
								if (fill_q >= FW'(FRAME_BYTES - 1)) begin
									ridx_q  <= wp_nxt;
									k_q     <= '0;
									state_q <= S_SCAN;
								end else begin
									state_q <= S_EMIT;
								end
							end
							FUNC_TX: begin
								if (pos_ok && pos_idx == LAST_IDX) begin
									echo_q <= 1'b1;
								end
								state_q <= S_EMIT;
							end
							FUNC_RESYNC: begin
								fill_q  <= '0;
								state_q <= S_EMIT;
							end
							FUNC_IDLE: begin
								fill_q  <= '0;
								echo_q  <= 1'b0;
								state_q <= S_EMIT;
							end
							FUNC_READ: begin
								state_q <= pos_ok ? S_RDCAP : S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_RDCAP: begin
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					ridx_q <= ridx_nxt;
					k_q    <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (crc_val != '0) begin
						state_q <= S_EMIT;
					end else if (echo_q && !crc_mismatch) begin
						echo_q  <= 1'b0;
						fill_q  <= '0;
						ev_q    <= EV_ECHO;
						state_q <= S_EMIT;
					end else begin
						// The read index has wrapped back to the oldest byte.
						fill_q  <= '0;
						ev_q    <= EV_CAPT;
						k_q     <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					ridx_q <= ridx_nxt;
					k_q    <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= S_COPY_END;
					end
				end
				S_COPY_END: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Read data and pipeline payload.
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (acc) begin
			rd_q <= '0;
		end else if (state_q == S_RDCAP) begin
			rd_q <= cap_rdata_q;
		end
	end

	// Shared CRC and compare unit drives the scan.
	assign crc_ctl.clear = acc && (item.func == FUNC_RX);
	assign crc_ctl.step  = rv_s1 && ((state_q == S_SCAN) || (state_q == S_SCAN_END));

	crcfs_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.win_byte  (win_rdata_s1),
		.sent_byte (sent_rdata_s1),
		.crc       (crc_val),
		.mismatch  (crc_mismatch)
	);

	// Window memory: received bytes in circular order.
	always_ff @(posedge clk) begin
		if (acc && item.func == FUNC_RX) begin
			win_mem[wp_q] <= item.data_byte;
		end
		win_rdata_s1 <= win_mem[ridx_q];
	end

	// Last transmitted frame.
	always_ff @(posedge clk) begin
		if (acc && item.func == FUNC_TX && pos_ok) begin
			sent_mem[pos_idx] <= item.data_byte;
		end
		sent_rdata_s1 <= sent_mem[k_q];
	end

	// Capture store, filled by the copy pass in frame order.
	assign cap_we = rv_s1 && ((state_q == S_COPY) || (state_q == S_COPY_END));

	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_mem[k_s1] <= win_rdata_s1;
		end
		cap_rdata_q <= cap_mem[pos_idx];
	end

	// Output register holds one finished result until it is taken.
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ev_q   <= ev_q;
			out_rd_q   <= rd_q;
			out_fill_q <= FILL_W'(fill_q);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.event_res  = out_ev_q;
	assign result.read_data  = out_rd_q;
	assign result.fill_level = out_fill_q;

`ifndef SYNTHESIS
	// The window never holds more than one frame.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("window fill exceeds frame length");

	// A CRC pass only runs over a full window.
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SCAN_END) |-> fill_q == FULL)
		else $error("CRC pass over a partial window");

	// A failed CRC keeps the window full.
	a_crc_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && crc_val != '0) |=> (fill_q == FULL && ev_q == EV_NONE))
		else $error("failed CRC changed the window");

	// The capture store is written only by the copy pass.
	a_cap_write: assert property (@(posedge clk) disable iff (!arst_n)
		cap_we |-> ev_q == EV_CAPT)
		else $error("capture write outside a frame copy");

	// A pending result is never overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !result.ready) |=> state_q == S_EMIT)
		else $error("result register overwritten while pending");
`endif

endmodule

// File: test/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame hunter. A queue of input transactions
// drives the item channel: a short directed opening, then random sequences
// of mostly valid frames, echoes of transmitted frames, capture reads, noise
// and resyncs. Each accepted transaction runs through a behavioral model of
// the hunter, and the result channel is compared against the predictions.
// -----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crcfs_pkg::*;

	localparam int FRAME        = FRAME_BYTES_DEF;
	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int TARGET_ITEMS = 950;
	localparam int IDLE_PCT     = 36;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 600;
	localparam int STEADY_FROM  = 500;
	localparam int STEADY_TO    = 700;
	localparam int DRAIN_CYCLES = 2 * FRAME + 16;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int MAX_REPORTS  = 10;

	typedef logic [FRAME-1:0][DATA_W-1:0] frame_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] data_byte;
		logic [POS_W-1:0]  position;
	} rx_item_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_res;
		logic [DATA_W-1:0]  read_data;
		logic [FILL_W-1:0]  fill_level;
	} hunt_res_t;

	// Full state of the frame hunter as the bench sees it.
	typedef struct packed {
		frame_t            window;
		frame_t            sent;
		frame_t            capture;
		logic [FILL_W-1:0] fill;
		logic              armed;
		logic              captured;
	} hunter_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	crcfs_in_if  item_ch ();
	crcfs_out_if result_ch ();

	crc_frame_sync_echo_filter #(
		.FRAME_BYTES(FRAME)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	rx_item_t  pending_items[$];
	hunt_res_t expected_results[$];
	hunter_t   plan_st;
	hunter_t   model_st;
	int        items_queued  = 0;
	int        counted_items = 0;
	int        items_taken   = 0;
	int        mismatches    = 0;
	logic      holding       = 1'b0;
	logic      hold_done     = 1'b0;
	int        hold_count    = 0;

	// One byte through the reflected CCITT CRC, fed bit by bit.
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] acc,
			input logic [DATA_W-1:0] byte_in);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = acc;
		for (int b = 0; b < DATA_W; b++) begin
			fb = c[0] ^ byte_in[b];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Advances the hunter by one transaction and reports its result.
	function automatic hunter_t hunt_step(input hunter_t st, input rx_item_t it,
			output hunt_res_t res);
		hunter_t          s;
		logic [CRC_W-1:0] rem;
		s   = st;
		res = '0;
		case (it.func)
			FUNC_RX: begin
				if (s.fill >= FRAME) begin
					for (int i = 0; i < FRAME - 1; i++) begin
						s.window[i] = s.window[i+1];
					end
					s.fill = FILL_W'(FRAME - 1);
				end
				s.window[s.fill] = it.data_byte;
				s.fill = s.fill + 1'b1;
				if (s.fill == FRAME) begin
					rem = '0;
					for (int i = 0; i < FRAME; i++) begin
						rem = crc_feed(rem, s.window[i]);
					end
					if (rem == '0) begin
						if (s.armed && s.window == s.sent) begin
							s.armed       = 1'b0;
							res.event_res = EV_ECHO;
						end else begin
							s.capture     = s.window;
							s.captured    = 1'b1;
							res.event_res = EV_CAPT;
						end
						s.fill = '0;
					end
				end
			end
			FUNC_TX: begin
				if (it.position < FRAME) begin
					s.sent[it.position] = it.data_byte;
					if (it.position == FRAME - 1) begin
						s.armed = 1'b1;
					end
				end
			end
			FUNC_RESYNC: begin
				s.fill = '0;
			end
			FUNC_IDLE: begin
				s.fill  = '0;
				s.armed = 1'b0;
			end
			FUNC_READ: begin
				if (it.position < FRAME) begin
					res.read_data = s.capture[it.position];
				end
			end
			default: begin
			end
		endcase
		res.fill_level = s.fill;
		return s;
	endfunction

	// Random frame whose last two bytes carry the CRC, so the remainder is zero.
	function automatic frame_t make_frame();
		frame_t           fr;
		logic [CRC_W-1:0] rem;
		rem = '0;
		for (int i = 0; i < FRAME - 2; i++) begin
			fr[i] = DATA_W'($urandom);
			rem   = crc_feed(rem, fr[i]);
		end
		fr[FRAME-2] = rem[7:0];
		fr[FRAME-1] = rem[15:8];
		return fr;
	endfunction

	// Both sides pause at random, except in the steady stretch and the hold-off.
	function automatic bit take_break();
		if (holding || (items_taken >= STEADY_FROM && items_taken < STEADY_TO)) begin
			return 1'b0;
		end
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// Queues one transaction and tracks the state it leaves behind.
	task automatic offer(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d,
			input logic [POS_W-1:0] p);
		rx_item_t  it;
		hunt_res_t ignored_res;
		it.func      = f;
		it.data_byte = d;
		it.position  = p;
		plan_st = hunt_step(plan_st, it, ignored_res);
		pending_items.push_back(it);
		items_queued++;
		if (!(f > FUNC_READ || (f == FUNC_TX && p >= FRAME))) begin
			counted_items++;
		end
	endtask

	task automatic send_frame(input frame_t fr);
		for (int i = 0; i < FRAME; i++) begin
			offer(FUNC_RX, fr[i], POS_W'($urandom));
		end
	endtask

	// Clock.
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		frame_t      fr;
		frame_t      last_tx;
		logic        tx_done;
		int unsigned pick;
		int unsigned n;
		int          leftover;

		arst_n <= 1'b0;
		plan_st = '0;
		tx_done = 1'b0;
		last_tx = '0;

		// Directed opening: out-of-range reads and writes, unused codes,
		// resync and timeout on an empty or partly filled window.
		offer(FUNC_READ, 8'h00, 7'd127);
		offer(FUNC_READ, 8'hFF, POS_W'(FRAME));
		offer(FUNC_TX, 8'hFF, POS_W'(FRAME));
		offer(FUNC_TX, 8'h00, 7'd127);
		offer(3'd5, 8'hFF, 7'd127);
		offer(3'd6, 8'h00, 7'd0);
		offer(3'd7, 8'hA5, 7'h5A);
		offer(FUNC_RESYNC, 8'h00, 7'd0);
		offer(FUNC_IDLE, 8'hFF, 7'd127);
		offer(FUNC_RX, 8'h00, 7'd0);
		offer(FUNC_RX, 8'hFF, 7'd127);
		offer(FUNC_RX, 8'h80, 7'd64);
		offer(FUNC_RX, 8'h01, 7'd1);
		offer(FUNC_RESYNC, 8'hFF, 7'd127);
		offer(FUNC_RX, 8'h7F, 7'd0);
		offer(FUNC_RX, 8'hFE, 7'd127);
		offer(FUNC_IDLE, 8'h00, 7'd0);
		offer(FUNC_RX, 8'h55, 7'h2A);
		offer(3'd7, 8'h00, 7'd0);

		// Random sequences. The first one records a complete transmitted
		// frame so that the echo compare never sees an unwritten byte.
		while (counted_items < TARGET_ITEMS) begin
			pick = $urandom_range(99);
			if (!tx_done || (pick >= 30 && pick < 42)) begin
				last_tx = make_frame();
				for (int i = 0; i < FRAME; i++) begin
					offer(FUNC_TX, last_tx[i], POS_W'(i));
				end
				tx_done = 1'b1;
			end else if (pick < 30) begin
				// Received frame, behind a resync or a few stray bytes.
				if ($urandom_range(1) == 0) begin
					offer(FUNC_RESYNC, DATA_W'($urandom), POS_W'($urandom));
				end else begin
					n = $urandom_range(4);
					for (int i = 0; i < n; i++) begin
						offer(FUNC_RX, DATA_W'($urandom), POS_W'($urandom));
					end
				end
				fr = make_frame();
				if ($urandom_range(4) == 0) begin
					fr[$urandom_range(FRAME - 1)] ^= DATA_W'(1 << $urandom_range(7));
				end
				send_frame(fr);
			end else if (pick < 55) begin
				// Our own frame coming back, sometimes after the echo mark is gone.
				if ($urandom_range(5) == 0) begin
					offer(FUNC_IDLE, DATA_W'($urandom), POS_W'($urandom));
				end else if ($urandom_range(1) == 0) begin
					offer(FUNC_RESYNC, DATA_W'($urandom), POS_W'($urandom));
				end
				send_frame(last_tx);
			end else if (pick < 70) begin
				// Capture reads stay out of range until a frame was captured.
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					if (plan_st.captured && $urandom_range(4) != 0) begin
						offer(FUNC_READ, DATA_W'($urandom), POS_W'($urandom_range(FRAME - 1)));
					end else begin
						offer(FUNC_READ, DATA_W'($urandom), POS_W'($urandom_range(FRAME, 127)));
					end
				end
			end else if (pick < 80) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					offer(FUNC_RX, DATA_W'($urandom), POS_W'($urandom));
				end
			end else if (pick < 86) begin
				if ($urandom_range(1) == 0) begin
					offer(FUNC_RESYNC, DATA_W'($urandom), POS_W'($urandom));
				end else begin
					offer(FUNC_IDLE, DATA_W'($urandom), POS_W'($urandom));
				end
			end else if (pick < 93) begin
				offer(FUNC_TX, DATA_W'($urandom), POS_W'($urandom_range(127)));
			end else begin
				offer(FUNC_W'($urandom_range(5, 7)), DATA_W'($urandom), POS_W'($urandom));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction to be taken and every result to arrive.
		while (items_taken < items_queued) begin
			@(posedge clk);
		end
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = expected_results.size();
		if (mismatches == 0 && leftover == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Driver: presents queued transactions and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin : drive_items
		rx_item_t  taken;
		rx_item_t  next_item;
		hunt_res_t predicted;
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.func      <= '0;
			item_ch.data_byte <= '0;
			item_ch.position  <= '0;
			model_st = '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				taken.func      = item_ch.func;
				taken.data_byte = item_ch.data_byte;
				taken.position  = item_ch.position;
				model_st = hunt_step(model_st, taken, predicted);
				expected_results.push_back(predicted);
				items_taken <= items_taken + 1;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() > 0 && !take_break()) begin
					next_item = pending_items.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.func      <= next_item.func;
					item_ch.data_byte <= next_item.data_byte;
					item_ch.position  <= next_item.position;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, so the block fills up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding    <= 1'b0;
			hold_done  <= 1'b0;
			hold_count <= 0;
		end else if (!hold_done) begin
			if (holding) begin
				if (hold_count == HOLD_CYCLES - 1) begin
					holding   <= 1'b0;
					hold_done <= 1'b1;
				end
				hold_count <= hold_count + 1;
			end else if (items_taken >= HOLD_AT) begin
				holding <= 1'b1;
			end
		end
	end

	// Monitor: compares each result transaction with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : check_results
		hunt_res_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					if (mismatches < MAX_REPORTS) begin
						$display("unexpected result: event %0d data %02h fill %0d",
							result_ch.event_res, result_ch.read_data, result_ch.fill_level);
					end
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (result_ch.event_res !== want.event_res
							|| result_ch.read_data !== want.read_data
							|| result_ch.fill_level !== want.fill_level) begin
						if (mismatches < MAX_REPORTS) begin
							$display("mismatch: expected event %0d data %02h fill %0d, got event %0d data %02h fill %0d",
								want.event_res, want.read_data, want.fill_level,
								result_ch.event_res, result_ch.read_data, result_ch.fill_level);
						end
						mismatches++;
					end
				end
			end
			result_ch.ready <= !holding && !take_break();
		end
	end

endmodule

// File: sim.f
rtl/crcfs_pkg.sv
rtl/crcfs_if.sv
rtl/crcfs_crc_unit.sv
rtl/crc_frame_sync_echo_filter.sv
test/tb.sv
